// ===== sv/agu_pkg.sv =====
// ----------------------------------------------------------------------------
// agu_pkg
// Shared types, codes and defaults for the activation and gradient unit.
// ----------------------------------------------------------------------------
package agu_pkg;

    // data path and bus sizes
    localparam int DATA_W          = 16;
    localparam int APB_W           = 32;
    localparam int ADDR_W          = 3;
    localparam int LUT_ENTRIES_DEF = 256;
    localparam int FRAC_BITS_DEF   = 12;

    // reset value of the leaky slope register, Q4.12
    localparam logic signed [DATA_W-1:0] SLOPE_RESET = 16'sd41;

    // activation modes; codes 6 and 7 behave like pass-through
    typedef enum logic [2:0] {
        MODE_LINEAR  = 3'd0,
        MODE_RELU    = 3'd1,
        MODE_LEAKY   = 3'd2,
        MODE_SIGMOID = 3'd3,
        MODE_TANH    = 3'd4,
        MODE_PASS    = 3'd5
    } mode_t;

    // register indexes on the configuration port
    typedef enum logic {
        REG_MODE  = 1'b0,
        REG_SLOPE = 1'b1
    } reg_idx_t;

    // configuration seen by the data path
    typedef struct packed {
        mode_t                      mode;
        logic signed [DATA_W-1:0]   leak_slope;
    } cfg_t;

    // per-request side information traveling down the pipeline
    typedef struct packed {
        mode_t                      mode;
        logic signed [DATA_W-1:0]   sample;
        logic signed [DATA_W-1:0]   leak_slope;
    } side_t;

endpackage

// ===== sv/agu_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// agu_cfg_regs
// APB register file holding the activation mode and the leaky slope.
// ----------------------------------------------------------------------------
module agu_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [agu_pkg::ADDR_W-1:0]    paddr,
    input  logic [agu_pkg::APB_W-1:0]     pwdata,
    output logic [agu_pkg::APB_W-1:0]     prdata,
    output logic                          pready,
    output agu_pkg::cfg_t                 cfg
);
    import agu_pkg::*;

    mode_t                    mode_reg;
    logic signed [DATA_W-1:0] slope_reg;
    reg_idx_t                 reg_sel;
    logic                     wr_en;

    // register select is the word address
    assign reg_sel = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_LINEAR;
            slope_reg <= SLOPE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_MODE:  mode_reg  <= mode_t'(pwdata[2:0]);
                REG_SLOPE: slope_reg <= pwdata[DATA_W-1:0];
                default:   ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_sel)
            REG_MODE:  prdata = {{(APB_W-3){1'b0}}, mode_reg};
            REG_SLOPE: prdata = {{(APB_W-DATA_W){slope_reg[DATA_W-1]}}, slope_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg.mode       = mode_reg;
    assign cfg.leak_slope = slope_reg;

endmodule

// ===== sv/agu_sigmoid.sv =====
// ----------------------------------------------------------------------------
// agu_sigmoid
// Three-stage sigmoid: table address, table read, linear interpolation.
// ----------------------------------------------------------------------------
module agu_sigmoid #(
    parameter int LUT_ENTRIES = agu_pkg::LUT_ENTRIES_DEF,
    parameter int FRAC_BITS   = agu_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  agu_pkg::side_t       in_side,
    output logic                 out_valid,
    output agu_pkg::side_t       out_side,
    output logic [FRAC_BITS:0]   out_sig
);
    import agu_pkg::*;

    localparam int RW     = FRAC_BITS + 1;
    localparam int SPAN_W = FRAC_BITS + 4;
    localparam int VW     = DATA_W + 1;
    localparam int MW     = (SPAN_W > VW) ? SPAN_W : VW;
    localparam int UW     = MW + 2;
    localparam int LW     = $clog2(LUT_ENTRIES + 1);
    localparam int NW     = SPAN_W + LW;
    localparam int IW     = $clog2(LUT_ENTRIES);
    localparam int AW     = RW + SPAN_W + 2;
    localparam int E_FRAC = 24;
    localparam logic [63:0] E_ONE = 64'd1 << E_FRAC;

    typedef logic [2*RW-1:0] pair_rom_t [LUT_ENTRIES];
    typedef logic [RW-1:0]   val_rom_t  [LUT_ENTRIES+1];

    // long division by shift and subtract, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        int          b;
        r = '0;
        q = '0;
        for (b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^t for t >= 0, 24 fraction bits, truncated series
    function automatic logic [63:0] exp_pos(input logic [63:0] t);
        logic [63:0] sum;
        logic [63:0] term;
        logic        stop;
        int          k;
        sum  = E_ONE;
        term = E_ONE;
        stop = 1'b0;
        for (k = 1; k < 80; k++)
        begin
            if (!stop)
            begin
                term = udiv64((term * t) >> E_FRAC, 64'(k));
                if (term == 64'd0)
                    stop = 1'b1;
                else
                    sum = sum + term;
            end
        end
        return sum;
    endfunction

    // sigmoid samples over [-8,8], packed as neighbor pairs
    function automatic pair_rom_t build_pair_rom();
        val_rom_t           vals;
        pair_rom_t          rom;
        logic signed [63:0] xs;
        logic [63:0]        mag;
        logic [63:0]        e;
        logic [63:0]        den;
        logic [63:0]        num;
        int                 i;
        for (i = 0; i <= LUT_ENTRIES; i++)
        begin
            xs  = $signed(((64'(i) * 64'd16) << E_FRAC) / 64'(LUT_ENTRIES))
                  - (64'sd8 <<< E_FRAC);
            mag = xs[63] ? 64'(-xs) : 64'(xs);
            e   = exp_pos(mag);
            den = E_ONE + e;
            num = xs[63] ? (E_ONE << FRAC_BITS) : (e << FRAC_BITS);
            vals[i] = RW'(udiv64(num + (den >> 1), den));
        end
        for (i = 0; i < LUT_ENTRIES; i++)
            rom[i] = {vals[i+1], vals[i]};
        return rom;
    endfunction

    localparam pair_rom_t PAIR_ROM = build_pair_rom();

    // stage 1 signals
    logic signed [VW-1:0] arg;
    logic signed [UW-1:0] pos;
    logic [SPAN_W-1:0]    pos_in;
    logic [NW-1:0]        scaled;
    logic                 below;
    logic                 above;
    logic [IW-1:0]        idx_next;

    logic                 valid1_reg;
    side_t                side1_reg;
    logic [IW-1:0]        idx1_reg;
    logic [SPAN_W-1:0]    rem1_reg;
    logic                 below1_reg;
    logic                 above1_reg;

    logic                 valid2_reg;
    side_t                side2_reg;
    logic [2*RW-1:0]      pair2_reg;
    logic [SPAN_W-1:0]    rem2_reg;
    logic                 below2_reg;
    logic                 above2_reg;

    logic                 valid3_reg;
    side_t                side3_reg;
    logic [RW-1:0]        sig3_reg;

    // stage 3 signals
    logic [RW-1:0]               lo_val;
    logic [RW-1:0]               hi_val;
    logic signed [RW:0]          step;
    logic signed [RW+SPAN_W+1:0] slope_part;
    logic signed [AW-1:0]        acc;
    logic [RW-1:0]               sig_next;

    // table position: tanh looks up sigmoid at twice the sample
    always_comb
    begin
        if (in_side.mode == MODE_TANH)
            arg = {in_side.sample, 1'b0};
        else
            arg = {in_side.sample[DATA_W-1], in_side.sample};
        pos    = {{(UW-VW){arg[VW-1]}}, arg} + (UW'(1) << (FRAC_BITS + 3));
        below  = pos[UW-1];
        above  = !pos[UW-1] && (pos[UW-2:SPAN_W] != '0);
        pos_in = pos[SPAN_W-1:0];
        scaled = NW'(pos_in) * NW'(LUT_ENTRIES);
        if (below)
            idx_next = '0;
        else if (above)
            idx_next = IW'(LUT_ENTRIES - 1);
        else
            idx_next = scaled[SPAN_W+IW-1:SPAN_W];
    end

    // interpolation between neighbor entries
    always_comb
    begin
        lo_val     = pair2_reg[RW-1:0];
        hi_val     = pair2_reg[2*RW-1:RW];
        step       = $signed({1'b0, hi_val}) - $signed({1'b0, lo_val});
        slope_part = step * $signed({1'b0, rem2_reg});
        acc        = $signed({2'b00, lo_val, {SPAN_W{1'b0}}})
                     + AW'(slope_part)
                     + $signed(AW'(1) << (SPAN_W - 1));
        if (above2_reg)
            sig_next = hi_val;
        else if (below2_reg)
            sig_next = lo_val;
        else
            sig_next = acc[SPAN_W+RW-1:SPAN_W];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        side1_reg  <= in_side;
        idx1_reg   <= idx_next;
        rem1_reg   <= scaled[SPAN_W-1:0];
        below1_reg <= below;
        above1_reg <= above;

        side2_reg  <= side1_reg;
        pair2_reg  <= PAIR_ROM[idx1_reg];
        rem2_reg   <= rem1_reg;
        below2_reg <= below1_reg;
        above2_reg <= above1_reg;

        side3_reg  <= side2_reg;
        sig3_reg   <= sig_next;
    end

    assign out_valid = valid3_reg;
    assign out_side  = side3_reg;
    assign out_sig   = sig3_reg;

endmodule

// ===== sv/agu_finish.sv =====
// ----------------------------------------------------------------------------
// agu_finish
// Shared product stage, rounding, mode select and saturation to 16 bits.
// ----------------------------------------------------------------------------
module agu_finish #(
    parameter int FRAC_BITS = agu_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  agu_pkg::side_t                      in_side,
    input  logic [FRAC_BITS:0]                  in_sig,
    output logic                                done,
    output logic signed [agu_pkg::DATA_W-1:0]   activated,
    output logic signed [agu_pkg::DATA_W-1:0]   derivative
);
    import agu_pkg::*;

    localparam int RW = FRAC_BITS + 1;
    localparam int OW = (FRAC_BITS + 2 > DATA_W) ? FRAC_BITS + 2 : DATA_W;
    localparam int PW = 2 * OW;
    localparam int ONE_Q = 1 << FRAC_BITS;
    localparam int HALF_Q = 1 << (FRAC_BITS - 1);
    localparam int LEAK_DEF = (ONE_Q + 50) / 100;

    // saturate a wide signed value to the output width
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PW-1:0] v);
        if ((v[PW-1:DATA_W-1] == '0) || (v[PW-1:DATA_W-1] == '1))
            return v[DATA_W-1:0];
        else if (v[PW-1])
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    logic signed [OW-1:0] sig_s;
    logic signed [OW-1:0] tanh_s;
    logic signed [OW-1:0] one_minus;
    logic signed [OW-1:0] alpha;
    logic signed [OW-1:0] op_a;
    logic signed [OW-1:0] op_b;

    logic                 valid4_reg;
    side_t                side4_reg;
    logic [RW-1:0]        sig4_reg;
    logic signed [PW-1:0] prod4_reg;

    logic signed [PW-1:0]     rnd_sum;
    logic signed [PW-1:0]     rnd;
    logic signed [OW-1:0]     tanh4;
    logic                     pos_x;
    logic signed [DATA_W-1:0] x4;
    logic signed [DATA_W-1:0] one_d;
    logic signed [DATA_W-1:0] act_next;
    logic signed [DATA_W-1:0] der_next;

    logic                     done_reg;
    logic signed [DATA_W-1:0] act_reg;
    logic signed [DATA_W-1:0] der_reg;

    // operand select for the single multiplier
    always_comb
    begin
        sig_s     = $signed(OW'(in_sig));
        tanh_s    = (sig_s <<< 1) - $signed(OW'(ONE_Q));
        one_minus = $signed(OW'(ONE_Q)) - sig_s;
        if (in_side.leak_slope > 0)
            alpha = OW'(in_side.leak_slope);
        else
            alpha = $signed(OW'(LEAK_DEF));
        case (in_side.mode)
            MODE_LEAKY:
            begin
                op_a = alpha;
                op_b = OW'(in_side.sample);
            end
            MODE_SIGMOID:
            begin
                op_a = sig_s;
                op_b = one_minus;
            end
            MODE_TANH:
            begin
                op_a = tanh_s;
                op_b = tanh_s;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // rounding to nearest, ties away from zero, then per-mode result
    always_comb
    begin
        rnd_sum = prod4_reg + $signed(PW'(HALF_Q)) - $signed(PW'(prod4_reg[PW-1]));
        rnd     = rnd_sum >>> FRAC_BITS;
        tanh4   = $signed({1'b0, sig4_reg, 1'b0}) - $signed(OW'(ONE_Q));
        x4      = side4_reg.sample;
        pos_x   = !x4[DATA_W-1] && (x4 != '0);
        one_d   = DATA_W'(ONE_Q);
        case (side4_reg.mode)
            MODE_LINEAR:
            begin
                act_next = x4;
                der_next = one_d;
            end
            MODE_RELU:
            begin
                act_next = pos_x ? x4 : '0;
                der_next = pos_x ? one_d : '0;
            end
            MODE_LEAKY:
            begin
                act_next = pos_x ? x4 : sat_data(rnd);
                der_next = pos_x ? one_d : side4_reg.leak_slope;
            end
            MODE_SIGMOID:
            begin
                act_next = DATA_W'(sig4_reg);
                der_next = sat_data(rnd);
            end
            MODE_TANH:
            begin
                act_next = DATA_W'(tanh4);
                der_next = sat_data($signed(PW'(ONE_Q)) - rnd);
            end
            default:
            begin
                act_next = x4;
                der_next = '0;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid4_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid4_reg <= in_valid;
            done_reg   <= valid4_reg;
        end
    end

    // product and output registers
    always_ff @(posedge clk)
    begin
        side4_reg <= in_side;
        sig4_reg  <= in_sig;
        prod4_reg <= op_a * op_b;
        act_reg   <= act_next;
        der_reg   <= der_next;
    end

    assign done       = done_reg;
    assign activated  = act_reg;
    assign derivative = der_reg;

endmodule

// ===== sv/activation_and_gradient_unit.sv =====
// ----------------------------------------------------------------------------
// activation_and_gradient_unit
// Activation value and derivative of one Q4.12 sample per clock.
// ----------------------------------------------------------------------------
// usage
//   request: drive sample and raise start; the request is taken at a rising
//   edge with start high and busy low. busy stays low, so a new request can
//   be taken on every clock.
//   result: activated and derivative are valid for one cycle with done high
//   and are taken at the edge that ends that cycle; there is no back-pressure.
//   throughput: one request per clock; each request passes the five register
//   stages (table address, table read, interpolation, shared multiplier,
//   round and saturate), and done rises as the last of them is loaded.
//   config: mode at byte address 0, leak_slope at byte address 4 over APB;
//   write only with no request in flight.
//   reset: rst_n clears the pipeline valid bits and loads mode 0 (linear)
//   and leak_slope 41; the sigmoid table is a constant and needs no fill.
// ----------------------------------------------------------------------------
module activation_and_gradient_unit #(
    parameter int LUT_ENTRIES = agu_pkg::LUT_ENTRIES_DEF,
    parameter int FRAC_BITS   = agu_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [agu_pkg::DATA_W-1:0]   sample,
    output logic                                done,
    output logic signed [agu_pkg::DATA_W-1:0]   activated,
    output logic signed [agu_pkg::DATA_W-1:0]   derivative,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [agu_pkg::ADDR_W-1:0]          paddr,
    input  logic [agu_pkg::APB_W-1:0]           pwdata,
    output logic [agu_pkg::APB_W-1:0]           prdata,
    output logic                                pready
);
    import agu_pkg::*;

    cfg_t               cfg;
    side_t              req_side;
    logic               req_valid;
    logic               sig_valid;
    side_t              sig_side;
    logic [FRAC_BITS:0] sig_val;

    // the pipeline never refuses a request
    assign busy      = 1'b0;
    assign req_valid = start && !busy;

    // request side data captured with the current configuration
    assign req_side.mode       = cfg.mode;
    assign req_side.sample     = sample;
    assign req_side.leak_slope = cfg.leak_slope;

    agu_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    agu_sigmoid #(
        .LUT_ENTRIES (LUT_ENTRIES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_sigmoid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_side   (req_side),
        .out_valid (sig_valid),
        .out_side  (sig_side),
        .out_sig   (sig_val)
    );

    agu_finish #(
        .FRAC_BITS (FRAC_BITS)
    ) u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sig_valid),
        .in_side    (sig_side),
        .in_sig     (sig_val),
        .done       (done),
        .activated  (activated),
        .derivative (derivative)
    );

endmodule

// ===== sv/agu_checker.sv =====
// ----------------------------------------------------------------------------
// agu_checker
// Port-level checks of request/result timing, bound to the top level.
// ----------------------------------------------------------------------------
module agu_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic                                psel,
    input logic                                pready
);
    logic accept;

    assign accept = start && !busy;

    // every request yields a result
    a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("request without result");

    // no result appears without an earlier request
    a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 5))
        else $error("result without request");

    // the pipeline never holds off requests
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // register port never waits
    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("pready low");

endmodule

bind activation_and_gradient_unit agu_checker u_agu_checker (.*);

// ===== test/agu_response_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agu_response_checker
// Watches the request, result and APB channels of the activation and
// gradient unit, predicts each response and compares it with the block.
// ----------------------------------------------------------------------------
module agu_response_checker
    import agu_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic signed [DATA_W-1:0]    sample,
    input  logic                        done,
    input  logic signed [DATA_W-1:0]    activated,
    input  logic signed [DATA_W-1:0]    derivative,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [APB_W-1:0]            pwdata,
    input  logic                        pready,
    output int                          mismatches,
    output int                          pending,
    output int                          requests_seen,
    output int                          results_checked
);

    localparam int      LUT_N   = LUT_ENTRIES_DEF;
    localparam int      FRAC    = FRAC_BITS_DEF;
    localparam int      E_FRAC  = 24;
    localparam longint  ONE_Q   = 64'sd1 <<< FRAC;
    localparam longint  HALF_Q  = 64'sd1 <<< (FRAC - 1);
    localparam longint  SPAN_Q  = 64'sd16 <<< FRAC;
    localparam longint unsigned ONE_E = 64'd1 << E_FRAC;
    localparam int      REPORT_MAX = 10;

    typedef struct {
        logic signed [DATA_W-1:0] act;
        logic signed [DATA_W-1:0] der;
    } response_t;

    response_t      expected_responses [$];
    longint         sigmoid_table [0:LUT_N];
    logic [2:0]     mode_q;
    longint         slope_q;

    // e^t for t >= 0, E_FRAC fraction bits, truncated series
    function automatic longint unsigned exp_taylor(input longint unsigned t);
        longint unsigned acc;
        longint unsigned term;
        acc  = ONE_E;
        term = ONE_E;
        for (int k = 1; k < 80; k++) begin
            term = ((term * t) >> E_FRAC) / longint'(k);
            if (term == 0)
                break;
            acc += term;
        end
        return acc;
    endfunction

    // sigmoid table over [-8, 8], built once
    initial
    begin
        longint unsigned ui;
        longint          x;
        longint unsigned mag;
        longint unsigned e;
        longint unsigned den;
        longint unsigned num;
        for (int i = 0; i <= LUT_N; i++) begin
            ui  = longint'(i);
            x   = longint'(((ui * 16) << E_FRAC) / longint'(LUT_N)) - (64'sd8 <<< E_FRAC);
            mag = (x >= 0) ? x : -x;
            e   = exp_taylor(mag);
            den = ONE_E + e;
            num = (x >= 0) ? (e << FRAC) : (ONE_E << FRAC);
            sigmoid_table[i] = longint'(16'((num + den / 2) / den));
        end
    end

    // nearest, ties away from zero, 2*FRAC fraction down to FRAC
    function automatic longint round_frac(input longint p);
        if (p >= 0)
            return (p + HALF_Q) >>> FRAC;
        return -((-p + HALF_Q) >>> FRAC);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return DATA_W'(v);
    endfunction

    // interpolated sigmoid, clamped outside the table span
    function automatic longint sigmoid_of(input longint v);
        longint u;
        longint n;
        longint idx;
        longint rem;
        u = v + (64'sd8 <<< FRAC);
        if (u < 0)
            return sigmoid_table[0];
        if (u >= SPAN_Q)
            return sigmoid_table[LUT_N];
        n   = u * LUT_N;
        idx = n / SPAN_Q;
        rem = n % SPAN_Q;
        return (sigmoid_table[idx] * (SPAN_Q - rem) + sigmoid_table[idx + 1] * rem
                + SPAN_Q / 2) / SPAN_Q;
    endfunction

    // activation and derivative for the current register settings
    function automatic response_t predict_response(input logic signed [DATA_W-1:0] s);
        response_t r;
        longint    x;
        longint    act;
        longint    der;
        longint    a;
        longint    sg;
        longint    t;
        x = longint'(s);
        case (mode_q)
            MODE_LINEAR:
            begin
                act = x;
                der = ONE_Q;
            end
            MODE_RELU:
            begin
                act = (x > 0) ? x : 0;
                der = (x > 0) ? ONE_Q : 0;
            end
            MODE_LEAKY:
            begin
                // a slope at or below zero falls back to 0.01 in the forward path only
                a   = (slope_q > 0) ? slope_q : (ONE_Q + 50) / 100;
                act = (x > 0) ? x : round_frac(a * x);
                der = (x > 0) ? ONE_Q : slope_q;
            end
            MODE_SIGMOID:
            begin
                sg  = sigmoid_of(x);
                act = sg;
                der = round_frac(sg * (ONE_Q - sg));
            end
            MODE_TANH:
            begin
                t   = 2 * sigmoid_of(2 * x) - ONE_Q;
                act = t;
                der = ONE_Q - round_frac(t * t);
            end
            default:
            begin
                act = x;
                der = 0;
            end
        endcase
        r.act = sat16(act);
        r.der = sat16(der);
        return r;
    endfunction

    // result check, request capture, register shadow
    always @(posedge clk or negedge rst_n)
    begin
        response_t exp_r;
        if (!rst_n) begin
            mode_q          = MODE_LINEAR;
            slope_q         = longint'(SLOPE_RESET);
            mismatches      = 0;
            requests_seen   = 0;
            results_checked = 0;
            expected_responses.delete();
        end else begin
            if (done) begin
                if (expected_responses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result %0d/%0d with no request outstanding",
                                 $realtime, activated, derivative);
                end else begin
                    exp_r = expected_responses.pop_front();
                    results_checked++;
                    if (activated !== exp_r.act) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: activated mismatch, expected %0d got %0d",
                                     $realtime, exp_r.act, activated);
                    end
                    if (derivative !== exp_r.der) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: derivative mismatch, expected %0d got %0d",
                                     $realtime, exp_r.der, derivative);
                    end
                end
            end
            if (start && !busy) begin
                expected_responses.push_back(predict_response(sample));
                requests_seen++;
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_MODE:  mode_q  = pwdata[2:0];
                    REG_SLOPE: slope_q = longint'($signed(pwdata[DATA_W-1:0]));
                endcase
            end
        end
        pending = expected_responses.size();
    end

endmodule

// ===== test/activation_and_gradient_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// activation_and_gradient_unit_tb
// Drives directed and random samples through every activation mode and a
// range of leaky slopes, with sender idle profiles and drains between
// register updates; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module activation_and_gradient_unit_tb;
    import agu_pkg::*;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SEG_ITEMS     = 100;
    localparam int          SEGS_PER_PHASE = 5;
    localparam int          TAIL_CYCLES   = 10;
    localparam logic [2:0]  MODE_SPARE_6  = 3'd6;
    localparam logic [2:0]  MODE_SPARE_7  = 3'd7;

    logic                       clk     = 1'b0;
    logic                       rst_n   = 1'b0;
    logic                       start   = 1'b0;
    logic signed [DATA_W-1:0]   sample  = '0;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [ADDR_W-1:0]          paddr   = '0;
    logic [APB_W-1:0]           pwdata  = '0;
    logic                       busy;
    logic                       done;
    logic signed [DATA_W-1:0]   activated;
    logic signed [DATA_W-1:0]   derivative;
    logic [APB_W-1:0]           prdata;
    logic                       pready;

    int                         mismatches;
    int                         pending;
    int                         requests_seen;
    int                         results_checked;
    int                         settings_applied = 0;
    logic [2:0]                 cur_mode  = MODE_LINEAR;
    logic signed [DATA_W-1:0]   cur_slope = SLOPE_RESET;

    always #5 clk = ~clk;

    activation_and_gradient_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .sample     (sample),
        .done       (done),
        .activated  (activated),
        .derivative (derivative),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    agu_response_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .sample          (sample),
        .done            (done),
        .activated       (activated),
        .derivative      (derivative),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .pending         (pending),
        .requests_seen   (requests_seen),
        .results_checked (results_checked)
    );

    // one request, after a random idle stretch when idle_pct allows
    task automatic send_sample(input logic signed [DATA_W-1:0] s, input int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start  <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // stop sending and wait until every outstanding result is back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // APB write: setup then access, then psel dropped
    task automatic write_reg(input reg_idx_t idx, input logic [APB_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // idle the block, then load mode and slope with random upper bits
    task automatic configure(input logic [2:0] m, input logic signed [DATA_W-1:0] sl);
        logic [APB_W-1:0] junk;
        drain_results();
        junk = $urandom();
        write_reg(REG_MODE, {junk[APB_W-1:3], m});
        junk = $urandom();
        write_reg(REG_SLOPE, {junk[APB_W-1:DATA_W], sl});
        cur_mode  = m;
        cur_slope = sl;
        settings_applied++;
    endtask

    task automatic directed(input logic [2:0] m, input logic signed [DATA_W-1:0] sl,
                            input logic signed [DATA_W-1:0] s);
        if (m != cur_mode || sl != cur_slope)
            configure(m, sl);
        send_sample(s, 0);
    endtask

    // mostly full range, some near zero, some corners
    function automatic logic signed [DATA_W-1:0] pick_sample();
        int          r;
        logic [31:0] w;
        r = $urandom_range(0, 9);
        w = $urandom();
        if (r == 0)
        begin
            case ($urandom_range(0, 5))
                0: return 16'sh8000;
                1: return 16'sh7fff;
                2: return 16'sd0;
                3: return 16'sd1;
                4: return -16'sd1;
                default: return 16'sh8001;
            endcase
        end
        if (r <= 3)
            return DATA_W'(int'($urandom_range(0, 10000)) - 5000);
        return w[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_slope();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 6))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sd0;
            3: return SLOPE_RESET;
            4: return DATA_W'($urandom_range(1, 512));
            5: return -DATA_W'($urandom_range(1, 512));
            default: return w[DATA_W-1:0];
        endcase
    endfunction

    // run watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        int idle_pct;
        int seg;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings first, then corners of every mode
        directed(MODE_LINEAR, SLOPE_RESET, 16'sh8000);
        directed(MODE_LINEAR, SLOPE_RESET, 16'sh7fff);
        directed(MODE_LINEAR, SLOPE_RESET, 16'sd0);
        directed(MODE_RELU, SLOPE_RESET, -16'sd1);
        directed(MODE_RELU, SLOPE_RESET, 16'sd1);
        directed(MODE_RELU, SLOPE_RESET, 16'sd0);
        directed(MODE_LEAKY, SLOPE_RESET, 16'sh8000);
        directed(MODE_LEAKY, SLOPE_RESET, -16'sd4096);
        // zero slope: forward path falls back to 0.01
        directed(MODE_LEAKY, 16'sd0, 16'sh8000);
        // negative slope: gradient keeps the raw register value
        directed(MODE_LEAKY, 16'sh8000, -16'sd12345);
        directed(MODE_LEAKY, 16'sh8000, 16'sh7fff);
        directed(MODE_LEAKY, 16'sh7fff, 16'sh8000);
        // sigmoid at the low table edge, just below the top, center, small step
        directed(MODE_SIGMOID, 16'sh7fff, 16'sh8000);
        directed(MODE_SIGMOID, 16'sh7fff, 16'sh7fff);
        directed(MODE_SIGMOID, 16'sh7fff, 16'sd0);
        directed(MODE_SIGMOID, 16'sh7fff, 16'sd16);
        // tanh with 2x below and above the table span
        directed(MODE_TANH, 16'sh7fff, 16'sh8000);
        directed(MODE_TANH, 16'sh7fff, 16'sd16384);
        directed(MODE_TANH, 16'sh7fff, 16'sd0);
        directed(MODE_TANH, 16'sh7fff, 16'sd1);
        directed(MODE_PASS, 16'sh7fff, 16'sh8000);
        // unused mode codes behave as pass-through
        directed(MODE_SPARE_6, 16'sh7fff, 16'sh7fff);
        directed(MODE_SPARE_7, 16'sh7fff, -16'sd1);

        // random: four phases over three idle profiles, new settings per segment
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 68;
                2: idle_pct = 0;
                default: idle_pct = 11;
            endcase
            for (int s = 0; s < SEGS_PER_PHASE; s++)
            begin
                seg = phase * SEGS_PER_PHASE + s;
                configure(3'(seg % 8), pick_slope());
                for (int n = 0; n < SEG_ITEMS; n++)
                begin
                    // sender holds off until the pipeline is empty
                    if (n == SEG_ITEMS / 2 && $urandom_range(0, 1) == 1)
                        drain_results();
                    send_sample(pick_sample(), idle_pct);
                end
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d requests under %0d register settings,",
                 requests_seen, settings_applied);
        $display("all modes and idle profiles; %0d results checked, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
